### rtl/core/lik_pkg.sv
// Package for the leg inverse kinematics block: widths, item and side-band types,
// CORDIC arc table and a leading-one search. No dependencies.
package lik_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int CN = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    localparam int IW = 42;   // CORDIC operand width
    localparam int CW = 45;   // CORDIC datapath width
    localparam int AW = 26;   // angle width, degrees*65536

    localparam logic [1:0] CFG_HIP   = 2'd0;
    localparam logic [1:0] CFG_FEMUR = 2'd1;
    localparam logic [1:0] CFG_TIBIA = 2'd2;

    typedef struct packed {
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic signed [19:0] z;
    } t_target;

    typedef struct packed {
        logic [15:0] hip;
        logic [15:0] femur;
        logic [15:0] tibia;
    } t_cfg;

    typedef struct packed {
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic signed [19:0] z;
        logic [20:0]        reach;
        logic               ok;
        logic [30:0]        a1;
        logic               neg1;
        logic [30:0]        a2;
        logic               neg2;
    } t_side;

    // atan(2^-i), degrees*65536
    localparam logic [22:0] ARC_TAB [0:31] = '{
        23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
        23'd58666, 23'd29335, 23'd14668, 23'd7334, 23'd3667, 23'd1833, 23'd917,
        23'd458, 23'd229, 23'd115, 23'd57, 23'd29, 23'd14, 23'd7, 23'd4, 23'd2,
        23'd1, 23'd0, 23'd0, 23'd0, 23'd0, 23'd0, 23'd0, 23'd0, 23'd0, 23'd0
    };

    function automatic logic [5:0] msb_pos(input logic [47:0] v);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < 48; i++) begin
            if (v[i]) begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

endpackage

### rtl/core/leg_inverse_kinematics.sv
// Top level of the leg inverse kinematics block: configuration registers,
// front queue and back pipeline. Depends on lik_pkg, lik_front, lik_back.
//
// Input channel: i_valid / o_stall with target x, y, z (mm*256, signed).
// Output channel: o_valid / i_stall with yaw, lift and bend angles in
// degrees*128 and a solved flag; unsolved items carry zero angles.
// Config channel: i_cfg_valid / o_cfg_ready (always ready), index 0 hip
// offset, 1 femur length, 2 tibia length; other indexes are ignored.
// Write configuration only while no item is in flight.
//
// One item per cycle sustained while the receiver does not stall. Between
// input accept and the output port lie three 32-step root pipelines in
// series and the CORDIC stages.
// When the receiver stalls a valid result, the whole back pipeline holds;
// the four-entry input queue keeps taking items until full, then o_stall rises.
// Reset clears the configuration registers to zero, empties the queue and the pipeline.
module leg_inverse_kinematics import lik_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [19:0] i_target_x,
    input  logic signed [19:0] i_target_y,
    input  logic signed [19:0] i_target_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_yaw_angle,
    output logic signed [16:0] o_lift_angle,
    output logic [14:0]        o_bend_angle,
    output logic               o_solved,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    t_cfg    r_cfg;
    t_target item;
    t_target head;
    logic    head_valid;
    logic    pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_HIP:   r_cfg.hip   <= i_cfg_data;
                CFG_FEMUR: r_cfg.femur <= i_cfg_data;
                CFG_TIBIA: r_cfg.tibia <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign item.x = i_target_x;
    assign item.y = i_target_y;
    assign item.z = i_target_z;

    lik_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_item(item),
        .i_pop(pop), .o_head_valid(head_valid), .o_head(head)
    );

    lik_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_head_valid(head_valid), .i_head(head), .o_pop(pop),
        .i_stall(i_stall), .o_valid(o_valid),
        .o_yaw_angle(o_yaw_angle), .o_lift_angle(o_lift_angle),
        .o_bend_angle(o_bend_angle), .o_solved(o_solved)
    );

endmodule

### rtl/core/lik_front.sv
// Front end: accepts foot target items and holds them in a short queue.
// Depends on lik_pkg.
module lik_front import lik_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_target i_item,
    input  logic    i_pop,
    output logic    o_head_valid,
    output t_target o_head
);

    t_target        r_q [0:QDEPTH-1];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0]   r_cnt;
    logic           push;
    logic           pop;

    assign o_stall      = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_q[r_rp];
    assign push         = i_valid && !o_stall;
    assign pop          = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QAW+1)'(push) - (QAW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_item;
        end
    end

endmodule

### rtl/core/lik_sqrt.sv
// Pipelined integer square root rounded to nearest, one result bit per stage.
// Depends on lik_pkg.
module lik_sqrt import lik_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_side       i_side,
    input  logic [61:0] i_rad,
    output logic        o_valid,
    output t_side       o_side,
    output logic [31:0] o_root
);

    logic [62:0] r_n [0:32];
    logic [62:0] r_r [0:32];
    logic        r_v [0:33];
    t_side       r_s [0:33];
    logic [31:0] r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 34; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < 34; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0] <= {1'b0, i_rad};
            r_r[0] <= '0;
            r_s[0] <= i_side;
        end
    end

    for (genvar g = 0; g < 32; g++) begin : g_stage
        localparam logic [62:0] B = 63'(1) << (62 - 2*g);
        logic [62:0] rb;
        logic        take;
        assign rb   = r_r[g] + B;
        assign take = (r_n[g] >= rb);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[g+1] <= take ? (r_n[g] - rb) : r_n[g];
                r_r[g+1] <= take ? ((r_r[g] >> 1) + B) : (r_r[g] >> 1);
                r_s[g+1] <= r_s[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_root <= r_r[32][31:0] + 32'(r_n[32] > r_r[32]);
            r_s[33] <= r_s[32];
        end
    end

    assign o_valid = r_v[33];
    assign o_side  = r_s[33];
    assign o_root  = r_root;

endmodule

### rtl/core/lik_cordic.sv
// Pipelined vectoring CORDIC: atan2(y, x) in degrees*65536, with operand
// normalization and quadrant fold. Depends on lik_pkg.
module lik_cordic import lik_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  t_side                i_side,
    input  logic signed [IW-1:0] i_y,
    input  logic signed [IW-1:0] i_x,
    output logic                 o_valid,
    output t_side                o_side,
    output logic signed [AW-1:0] o_angle
);

    logic signed [IW-1:0] r_px;
    logic signed [IW-1:0] r_py;
    logic [5:0]           r_psh;
    logic                 r_pz;
    logic                 r_pv;
    t_side                r_ps;

    logic [IW-1:0] ax;
    logic [IW-1:0] ay;
    logic [5:0]    m;

    logic signed [CW-1:0] r_cx [0:CN];
    logic signed [CW-1:0] r_cy [0:CN];
    logic signed [AW-1:0] r_ca [0:CN];
    logic                 r_cz [0:CN];
    logic                 r_cv [0:CN];
    t_side                r_cs [0:CN];

    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [CW-1:0] x0;
    logic signed [CW-1:0] y0;
    logic signed [AW-1:0] a0;

    assign ax = (i_x < 0) ? IW'(-i_x) : IW'(i_x);
    assign ay = (i_y < 0) ? IW'(-i_y) : IW'(i_y);
    assign m  = msb_pos(48'(ax | ay));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            for (int k = 0; k <= CN; k++) begin
                r_cv[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_pv    <= i_valid;
            r_cv[0] <= r_pv;
            for (int k = 1; k <= CN; k++) begin
                r_cv[k] <= r_cv[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px  <= i_x;
            r_py  <= i_y;
            r_psh <= (m >= 6'd40) ? 6'd0 : (6'd40 - m);
            r_pz  <= ((ax | ay) == '0);
            r_ps  <= i_side;
        end
    end

    assign xs = CW'(r_px) <<< r_psh;
    assign ys = CW'(r_py) <<< r_psh;

    always_comb begin
        x0 = xs;
        y0 = ys;
        a0 = '0;
        if (xs < 0) begin
            if (ys >= 0) begin
                x0 = ys;
                y0 = -xs;
                a0 = AW'(90 * 65536);
            end else begin
                x0 = -ys;
                y0 = xs;
                a0 = -AW'(90 * 65536);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cx[0] <= x0;
            r_cy[0] <= y0;
            r_ca[0] <= a0;
            r_cz[0] <= r_pz;
            r_cs[0] <= r_ps;
        end
    end

    for (genvar g = 0; g < CN; g++) begin : g_iter
        localparam logic signed [AW-1:0] ARC = $signed({3'b0, ARC_TAB[g]});
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        assign dx = r_cy[g] >>> g;
        assign dy = r_cx[g] >>> g;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_cy[g] > 0) begin
                    r_cx[g+1] <= r_cx[g] + dx;
                    r_cy[g+1] <= r_cy[g] - dy;
                    r_ca[g+1] <= r_ca[g] + ARC;
                end else begin
                    r_cx[g+1] <= r_cx[g] - dx;
                    r_cy[g+1] <= r_cy[g] + dy;
                    r_ca[g+1] <= r_ca[g] - ARC;
                end
                r_cz[g+1] <= r_cz[g];
                r_cs[g+1] <= r_cs[g];
            end
        end
    end

    assign o_valid = r_cv[CN];
    assign o_side  = r_cs[CN];
    assign o_angle = r_cz[CN] ? '0 : r_ca[CN];

endmodule

### rtl/core/lik_back.sv
// Back end: radii, reach clamp, law of cosines terms, acos preparation,
// angle CORDICs and the output register. Depends on lik_pkg, lik_sqrt, lik_cordic.
module lik_back import lik_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_head_valid,
    input  t_target            i_head,
    output logic               o_pop,
    input  logic               i_stall,
    output logic               o_valid,
    output logic signed [15:0] o_yaw_angle,
    output logic signed [16:0] o_lift_angle,
    output logic [14:0]        o_bend_angle,
    output logic               o_solved
);

    function automatic logic signed [19:0] round_clamp(input logic signed [27:0] v,
                                                       input logic signed [27:0] lo,
                                                       input logic signed [27:0] hi);
        logic signed [27:0] t;
        t = (v + 28'sd256) >>> 9;
        if (t < lo) t = lo;
        if (t > hi) t = hi;
        return t[19:0];
    endfunction

    function automatic logic [61:0] norm_pair(input logic [34:0] an, input logic [33:0] m,
                                              input logic [5:0] p);
        logic [65:0] ae;
        logic [65:0] be;
        if (p > 6'd30) begin
            ae = 66'(an) >> (p - 6'd30);
            be = 66'(m) >> (p - 6'd30);
        end else begin
            ae = 66'(an) << (6'd30 - p);
            be = 66'(m) << (6'd30 - p);
        end
        return {ae[30:0], be[30:0]};
    endfunction

    logic en;
    logic r_ov;

    assign en    = !r_ov || !i_stall;
    assign o_pop = en && i_head_valid;

    // B0
    logic  r0_v;
    t_side r0_s;
    t_side s0;
    always_comb begin
        s0   = '0;
        s0.x = i_head.x;
        s0.y = i_head.y;
        s0.z = i_head.z;
    end

    // B1
    logic               r1_v;
    t_side              r1_s;
    logic [38:0]        r1_xx;
    logic [38:0]        r1_yy;
    logic signed [39:0] px;
    logic signed [39:0] py;
    assign px = r0_s.x * r0_s.x;
    assign py = r0_s.y * r0_s.y;

    logic        q1_v;
    t_side       q1_s;
    logic [31:0] q1_root;
    logic [39:0] rad1;
    assign rad1 = {1'b0, r1_xx} + {1'b0, r1_yy};

    lik_sqrt u_sqrt_r (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(r1_v), .i_side(r1_s), .i_rad({22'b0, rad1}),
        .o_valid(q1_v), .o_side(q1_s), .o_root(q1_root)
    );

    // B3
    logic               r3_v;
    t_side              r3_s;
    logic signed [32:0] rdiff;
    t_side              s3;
    assign rdiff = $signed({1'b0, q1_root}) - $signed({17'b0, i_cfg.hip});
    always_comb begin
        s3       = q1_s;
        s3.reach = (rdiff < 0) ? '0 : rdiff[20:0];
    end

    // B4
    logic               r4_v;
    t_side              r4_s;
    logic [41:0]        r4_rr;
    logic [38:0]        r4_zz;
    logic signed [39:0] pz;
    assign pz = r3_s.z * r3_s.z;

    logic        q2_v;
    t_side       q2_s;
    logic [31:0] q2_root;
    logic [42:0] rad2;
    assign rad2 = {1'b0, r4_rr} + {4'b0, r4_zz};

    lik_sqrt u_sqrt_d (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(r4_v), .i_side(r4_s), .i_rad({19'b0, rad2}),
        .o_valid(q2_v), .o_side(q2_s), .o_root(q2_root)
    );

    // B6
    logic        r6_v;
    t_side       r6_s;
    logic [16:0] r6_d;
    logic [16:0] lsum;
    assign lsum = {1'b0, i_cfg.femur} + {1'b0, i_cfg.tibia};

    // B7
    logic        r7_v;
    t_side       r7_s;
    logic [31:0] r7_ff;
    logic [31:0] r7_tt;
    logic [33:0] r7_dd;
    logic [32:0] r7_fd;
    logic [31:0] r7_ft;

    // B8
    logic               r8_v;
    t_side              r8_s;
    logic signed [35:0] r8_n1;
    logic signed [35:0] r8_n2;
    logic [33:0]        r8_m1;
    logic [33:0]        r8_m2;

    // B9
    logic        r9_v;
    t_side       r9_s;
    logic [34:0] r9_an1;
    logic [34:0] r9_an2;
    logic [33:0] r9_m1;
    logic [33:0] r9_m2;
    logic [5:0]  r9_p1;
    logic [5:0]  r9_p2;
    logic [35:0] an1;
    logic [35:0] an2;
    t_side       s9;
    assign an1 = (r8_n1 < 0) ? 36'(-r8_n1) : 36'(r8_n1);
    assign an2 = (r8_n2 < 0) ? 36'(-r8_n2) : 36'(r8_n2);
    always_comb begin
        s9      = r8_s;
        s9.neg1 = (r8_n1 < 0);
        s9.neg2 = (r8_n2 < 0);
        s9.ok   = (r8_m1 != '0) && (r8_m2 != '0) &&
                  (an1 <= {2'b0, r8_m1}) && (an2 <= {2'b0, r8_m2});
    end

    // B10
    logic        r10_v;
    t_side       r10_s;
    logic [30:0] r10_b1;
    logic [30:0] r10_b2;
    logic [61:0] np1;
    logic [61:0] np2;
    t_side       s10;
    assign np1 = norm_pair(r9_an1, r9_m1, r9_p1);
    assign np2 = norm_pair(r9_an2, r9_m2, r9_p2);
    always_comb begin
        s10    = r9_s;
        s10.a1 = np1[61:31];
        s10.a2 = np2[61:31];
    end

    // B11
    logic        r11_v;
    t_side       r11_s;
    logic [61:0] r11_bb1;
    logic [61:0] r11_aa1;
    logic [61:0] r11_bb2;
    logic [61:0] r11_aa2;

    logic        q3_v;
    t_side       q3_s;
    logic [31:0] q3_s1;
    logic [31:0] q3_s2;

    lik_sqrt u_sqrt_c1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(r11_v), .i_side(r11_s), .i_rad(r11_bb1 - r11_aa1),
        .o_valid(q3_v), .o_side(q3_s), .o_root(q3_s1)
    );

    lik_sqrt u_sqrt_c2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(r11_v), .i_side(r11_s), .i_rad(r11_bb2 - r11_aa2),
        .o_valid(), .o_side(), .o_root(q3_s2)
    );

    logic signed [IW-1:0] a1x;
    logic signed [IW-1:0] a2x;
    assign a1x = q3_s.neg1 ? -$signed({11'b0, q3_s.a1}) : $signed({11'b0, q3_s.a1});
    assign a2x = q3_s.neg2 ? -$signed({11'b0, q3_s.a2}) : $signed({11'b0, q3_s.a2});

    logic                 cy_v;
    t_side                cy_s;
    logic signed [AW-1:0] ang_yaw;
    logic signed [AW-1:0] ang_l2;
    logic signed [AW-1:0] ang_c1;
    logic signed [AW-1:0] ang_c2;

    lik_cordic u_cordic_yaw (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(q3_v), .i_side(q3_s),
        .i_y(IW'(q3_s.y)), .i_x(IW'(q3_s.x)),
        .o_valid(cy_v), .o_side(cy_s), .o_angle(ang_yaw)
    );

    lik_cordic u_cordic_tilt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(q3_v), .i_side(q3_s),
        .i_y(-IW'(q3_s.z)), .i_x($signed({21'b0, q3_s.reach})),
        .o_valid(), .o_side(), .o_angle(ang_l2)
    );

    lik_cordic u_cordic_c1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(q3_v), .i_side(q3_s),
        .i_y($signed({10'b0, q3_s1})), .i_x(a1x),
        .o_valid(), .o_side(), .o_angle(ang_c1)
    );

    lik_cordic u_cordic_c2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(q3_v), .i_side(q3_s),
        .i_y($signed({10'b0, q3_s2})), .i_x(a2x),
        .o_valid(), .o_side(), .o_angle(ang_c2)
    );

    logic signed [19:0] yv;
    logic signed [19:0] lv;
    logic signed [19:0] bv;
    assign yv = round_clamp(28'(ang_yaw), -28'sd23040, 28'sd23040);
    assign lv = round_clamp(28'(ang_c1) - 28'(ang_l2), -28'sd23040, 28'sd46080);
    assign bv = round_clamp(28'sd11796480 - 28'(ang_c2), 28'sd0, 28'sd23040);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v  <= 1'b0;
            r1_v  <= 1'b0;
            r3_v  <= 1'b0;
            r4_v  <= 1'b0;
            r6_v  <= 1'b0;
            r7_v  <= 1'b0;
            r8_v  <= 1'b0;
            r9_v  <= 1'b0;
            r10_v <= 1'b0;
            r11_v <= 1'b0;
            r_ov  <= 1'b0;
        end else if (en) begin
            r0_v  <= i_head_valid;
            r1_v  <= r0_v;
            r3_v  <= q1_v;
            r4_v  <= r3_v;
            r6_v  <= q2_v;
            r7_v  <= r6_v;
            r8_v  <= r7_v;
            r9_v  <= r8_v;
            r10_v <= r9_v;
            r11_v <= r10_v;
            r_ov  <= cy_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_s    <= s0;
            r1_s    <= r0_s;
            r1_xx   <= px[38:0];
            r1_yy   <= py[38:0];
            r3_s    <= s3;
            r4_s    <= r3_s;
            r4_rr   <= r3_s.reach * r3_s.reach;
            r4_zz   <= pz[38:0];
            r6_s    <= q2_s;
            r6_d    <= (q2_root > {15'b0, lsum}) ? lsum : q2_root[16:0];
            r7_s    <= r6_s;
            r7_ff   <= i_cfg.femur * i_cfg.femur;
            r7_tt   <= i_cfg.tibia * i_cfg.tibia;
            r7_dd   <= r6_d * r6_d;
            r7_fd   <= r6_d * i_cfg.femur;
            r7_ft   <= i_cfg.femur * i_cfg.tibia;
            r8_s    <= r7_s;
            r8_n1   <= $signed({4'b0, r7_ff}) + $signed({2'b0, r7_dd}) - $signed({4'b0, r7_tt});
            r8_n2   <= $signed({4'b0, r7_ff}) + $signed({4'b0, r7_tt}) - $signed({2'b0, r7_dd});
            r8_m1   <= {r7_fd, 1'b0};
            r8_m2   <= {1'b0, r7_ft, 1'b0};
            r9_s    <= s9;
            r9_an1  <= an1[34:0];
            r9_an2  <= an2[34:0];
            r9_m1   <= r8_m1;
            r9_m2   <= r8_m2;
            r9_p1   <= msb_pos(48'(r8_m1));
            r9_p2   <= msb_pos(48'(r8_m2));
            r10_s   <= s10;
            r10_b1  <= np1[30:0];
            r10_b2  <= np2[30:0];
            r11_s   <= r10_s;
            r11_bb1 <= r10_b1 * r10_b1;
            r11_aa1 <= r10_s.a1 * r10_s.a1;
            r11_bb2 <= r10_b2 * r10_b2;
            r11_aa2 <= r10_s.a2 * r10_s.a2;
            o_yaw_angle  <= cy_s.ok ? yv[15:0] : '0;
            o_lift_angle <= cy_s.ok ? lv[16:0] : '0;
            o_bend_angle <= cy_s.ok ? bv[14:0] : '0;
            o_solved     <= cy_s.ok;
        end
    end

    assign o_valid = r_ov;

endmodule

### rtl/core/lik_checker.sv
// Port-level checks for leg_inverse_kinematics, bound to the top level.
// Depends on nothing but the top level's ports.
module lik_port_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [15:0] o_yaw_angle,
    input logic signed [16:0] o_lift_angle,
    input logic [14:0]        o_bend_angle,
    input logic               o_solved
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_yaw_angle) && $stable(o_lift_angle)
            && $stable(o_bend_angle) && $stable(o_solved))
        else $error("stalled result changed");

    a_unsolved_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_solved |-> o_yaw_angle == 16'sd0 && o_lift_angle == 17'sd0
            && o_bend_angle == 15'd0)
        else $error("unsolved item with nonzero angles");

    a_bend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_bend_angle <= 15'd23040)
        else $error("bend angle out of range");

endmodule

bind leg_inverse_kinematics lik_port_checker u_lik_checker (.*);
